@@ sv/dq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue
// no dependencies

package dq_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned DataW        = 32;
  localparam int unsigned PosW         = 16;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  localparam logic EndFront = 1'b0;
  localparam logic EndBack  = 1'b1;

endpackage

@@ sv/dq_ram.sv @@
`timescale 1ns / 1ps
// entry store: single-port synchronous ram with registered read data
// depends on dq_pkg

module dq_ram #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault,
  localparam int unsigned PtrW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [PtrW-1:0]            addr_i,
  input  logic [dq_pkg::DataW-1:0]   wdata_i,
  output logic [dq_pkg::DataW-1:0]   rdata_o
);

  logic [dq_pkg::DataW-1:0] mem_q [DEPTH];
  logic [dq_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dq_ctrl.sv @@
`timescale 1ns / 1ps
// front pointer, occupancy and status logic; drives the ram port
// depends on dq_pkg

module dq_ctrl #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                opcode_i,
  input  logic                      which_end_i,
  input  logic [dq_pkg::DataW-1:0]  push_value_i,
  input  logic [dq_pkg::PosW-1:0]   read_position_i,
  output logic                      mem_we_o,
  output logic                      mem_re_o,
  output logic [PtrW-1:0]           mem_addr_o,
  output logic [dq_pkg::DataW-1:0]  mem_wdata_o,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic                      rd_ok_o,
  output logic [CntW-1:0]           count_o
);

  localparam logic [PtrW:0]   DepthS = (PtrW + 1)'(DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [PtrW-1:0]       front_q, front_d;
  logic [CntW-1:0]       occ_q, occ_d;
  logic                  done_q;
  logic                  rd_ok_q, rd_ok_d;
  dq_pkg::status_e       status_q, status_d;

  dq_pkg::op_e           op;
  logic                  full, empty, in_range;
  logic [PtrW-1:0]       front_dec, front_inc, back_idx, rd_idx;
  logic [PtrW:0]         back_sum, rd_sum;

  assign op = dq_pkg::op_e'(opcode_i);

  assign full     = (occ_q == FullCnt);
  assign empty    = (occ_q == '0);
  assign in_range = 32'(read_position_i) < 32'(occ_q);

  assign front_dec = (front_q == '0) ? LastIdx : front_q - PtrW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + PtrW'(1);

  // ring wrap: sums stay below twice the depth
  assign back_sum = {1'b0, front_q} + {1'b0, occ_q[PtrW-1:0]};
  assign rd_sum   = {1'b0, front_q} + {1'b0, read_position_i[PtrW-1:0]};
  assign back_idx = (back_sum >= DepthS) ? PtrW'(back_sum - DepthS) : back_sum[PtrW-1:0];
  assign rd_idx   = (rd_sum >= DepthS) ? PtrW'(rd_sum - DepthS) : rd_sum[PtrW-1:0];

  always_comb begin
    front_d     = front_q;
    occ_d       = occ_q;
    status_d    = status_q;
    rd_ok_d     = rd_ok_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = rd_idx;
    mem_wdata_o = push_value_i;
    if (start_i) begin
      status_d = dq_pkg::ST_OK;
      rd_ok_d  = 1'b0;
      case (op)
        dq_pkg::OP_PUSH: begin
          if (full) begin
            status_d = dq_pkg::ST_FULL;
          end else if (which_end_i == dq_pkg::EndBack) begin
            mem_we_o   = 1'b1;
            mem_addr_o = back_idx;
            occ_d      = occ_q + CntW'(1);
          end else begin
            mem_we_o   = 1'b1;
            mem_addr_o = front_dec;
            front_d    = front_dec;
            occ_d      = occ_q + CntW'(1);
          end
        end
        dq_pkg::OP_READ: begin
          if (!in_range) begin
            status_d = dq_pkg::ST_RANGE;
          end else begin
            mem_re_o = 1'b1;
            rd_ok_d  = 1'b1;
          end
        end
        dq_pkg::OP_POP: begin
          if (empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            if (which_end_i == dq_pkg::EndFront) begin
              front_d = front_inc;
            end
            occ_d = occ_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      occ_q    <= '0;
      done_q   <= 1'b0;
      rd_ok_q  <= 1'b0;
      status_q <= dq_pkg::ST_OK;
    end else begin
      front_q  <= front_d;
      occ_q    <= occ_d;
      done_q   <= start_i;
      rd_ok_q  <= rd_ok_d;
      status_q <= status_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign rd_ok_o  = rd_ok_q;
  assign count_o  = occ_q;

endmodule

@@ sv/double_ended_queue.sv @@
`timescale 1ns / 1ps
// double-ended queue top level: control plus entry ram
// depends on dq_pkg, dq_ctrl, dq_ram
//
// Usage
//   Raise start_i for one cycle with opcode_i, which_end_i, push_value_i and
//   read_position_i; the item is taken at that edge when busy_o is low.
//   busy_o stays low: an item can be issued in every cycle.
//   Opcodes: push, indexed read (position counted from the front), pop,
//   and a no-op code. which_end_i picks front or back for push and pop.
//   In the cycle after the item is taken, done_o is high for one cycle
//   with status_o, read_data_o and entry_count_o (count after the item).
//   read_data_o holds the word on a good read and zero otherwise.
//   Throughput one item per clock; the single ram port (one write or one read
//   per item) serves each item, and its read data is registered.
//   Results cannot be held off by the receiver; it must take them as shown.
//   Reset empties the queue (front pointer and count to zero); the ram
//   needs no clearing, since only occupied entries are ever read.

module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       opcode_i,
  input  logic                             which_end_i,
  input  logic signed [dq_pkg::DataW-1:0]  push_value_i,
  input  logic [dq_pkg::PosW-1:0]          read_position_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic signed [dq_pkg::DataW-1:0]  read_data_o,
  output logic [CntW-1:0]                  entry_count_o
);

  logic                      mem_we, mem_re, rd_ok;
  logic [PtrW-1:0]           mem_addr;
  logic [dq_pkg::DataW-1:0]  mem_wdata, mem_rdata;

  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .which_end_i    (which_end_i),
    .push_value_i   (push_value_i),
    .read_position_i(read_position_i),
    .mem_we_o       (mem_we),
    .mem_re_o       (mem_re),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .done_o         (done_o),
    .status_o       (status_o),
    .rd_ok_o        (rd_ok),
    .count_o        (entry_count_o)
  );

  dq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign busy_o      = 1'b0;
  assign read_data_o = rd_ok ? mem_rdata : '0;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for double_ended_queue: directed, fill/drain and random items
// scored against an in-bench copy of the ring; depends on dq_pkg and double_ended_queue

module tb;

  localparam int unsigned Depth     = 64;
  localparam int unsigned PtrW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned IdleLimit = 2000;

  typedef struct packed {
    dq_pkg::status_e                 status;
    logic signed [dq_pkg::DataW-1:0] data;
    logic [CntW-1:0]                 count;
  } deque_result_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            start_i         = 1'b0;
  logic [1:0]                      opcode_i        = dq_pkg::OP_NOP;
  logic                            which_end_i     = dq_pkg::EndFront;
  logic signed [dq_pkg::DataW-1:0] push_value_i    = '0;
  logic [dq_pkg::PosW-1:0]         read_position_i = '0;
  logic                            busy_o;
  logic                            done_o;
  logic [1:0]                      status_o;
  logic signed [dq_pkg::DataW-1:0] read_data_o;
  logic [CntW-1:0]                 entry_count_o;

  logic signed [dq_pkg::DataW-1:0] ring_copy [Depth];
  int unsigned                     head_copy;
  int unsigned                     fill_copy;
  deque_result_t                   expected_results [$];
  int                              mismatch_count;
  int                              burst_left;
  int                              idle_cycles;

  double_ended_queue #(.DEPTH(Depth)) uut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .opcode_i,
    .which_end_i,
    .push_value_i,
    .read_position_i,
    .done_o,
    .status_o,
    .read_data_o,
    .entry_count_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic deque_result_t predict_deque(dq_pkg::op_e op, logic end_sel,
                                                  logic signed [dq_pkg::DataW-1:0] val,
                                                  logic [dq_pkg::PosW-1:0] pos);
    deque_result_t r;
    r.status = dq_pkg::ST_OK;
    r.data   = '0;
    case (op)
      dq_pkg::OP_PUSH: begin
        if (fill_copy >= Depth) begin
          r.status = dq_pkg::ST_FULL;
        end else if (end_sel == dq_pkg::EndBack) begin
          ring_copy[PtrW'((head_copy + fill_copy) % Depth)] = val;
          fill_copy++;
        end else begin
          head_copy = (head_copy + Depth - 1) % Depth;
          ring_copy[PtrW'(head_copy)] = val;
          fill_copy++;
        end
      end
      dq_pkg::OP_READ: begin
        if (pos >= fill_copy) r.status = dq_pkg::ST_RANGE;
        else r.data = ring_copy[PtrW'((head_copy + pos) % Depth)];
      end
      dq_pkg::OP_POP: begin
        if (fill_copy == 0) begin
          r.status = dq_pkg::ST_EMPTY;
        end else begin
          if (end_sel == dq_pkg::EndFront) head_copy = (head_copy + 1) % Depth;
          fill_copy--;
        end
      end
      default: ;
    endcase
    r.count = fill_copy[CntW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [dq_pkg::DataW-1:0] got,
                                 logic [dq_pkg::DataW-1:0] want);
    $display("mismatch %s at %0t: got %h, expected %h", what, $realtime, got, want);
    mismatch_count++;
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic send_item(dq_pkg::op_e op, logic end_sel,
                           logic signed [dq_pkg::DataW-1:0] val,
                           logic [dq_pkg::PosW-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i         <= 1'b1;
    opcode_i        <= op;
    which_end_i     <= end_sel;
    push_value_i    <= val;
    read_position_i <= pos;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_results.push_back(predict_deque(op, end_sel, val, pos));
  endtask

  task automatic wait_settled();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int push_weight);
    int r;
    logic [dq_pkg::PosW-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_item(dq_pkg::OP_NOP, 1'($urandom), $urandom, 16'($urandom));
    end else if (r < 23) begin
      case ($urandom_range(0, 7))
        0, 1:    pos = 16'($urandom);
        2:       pos = fill_copy[dq_pkg::PosW-1:0];
        default: pos = (fill_copy == 0) ? 16'($urandom) : 16'($urandom_range(0, fill_copy - 1));
      endcase
      send_item(dq_pkg::OP_READ, 1'($urandom), $urandom, pos);
    end else if (r < 23 + push_weight) begin
      send_item(dq_pkg::OP_PUSH, 1'($urandom), $urandom, 16'($urandom));
    end else begin
      send_item(dq_pkg::OP_POP, 1'($urandom), $urandom, 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_item(dq_pkg::OP_POP,  dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_POP,  dq_pkg::EndBack,  32'sd0, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndBack,  32'sd0, 16'hffff);
    send_item(dq_pkg::OP_NOP,  dq_pkg::EndBack,  -32'sd1, 16'hffff);
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndFront, 32'sh8000_0000, 16'd0);
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndBack,  32'sh7fff_ffff, 16'd0);
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndFront, 32'sd0, 16'hffff);
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndBack,  -32'sd1, 16'd0);
    for (int i = 0; i < 5; i++) send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'(i));
    send_item(dq_pkg::OP_NOP,  dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_POP,  dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_POP,  dq_pkg::EndBack,  32'sd0, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'd1);
    send_item(dq_pkg::OP_POP,  dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_POP,  dq_pkg::EndBack,  32'sd0, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndBack,  32'sh1234_5678, 16'd0);
    send_item(dq_pkg::OP_POP,  dq_pkg::EndFront, 32'sd0, 16'd0);
  endtask

  task automatic test_fill_drain();
    while (fill_copy < Depth)
      send_item(dq_pkg::OP_PUSH, 1'($urandom), $urandom, 16'($urandom));
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndFront, $urandom, 16'd0);
    send_item(dq_pkg::OP_PUSH, dq_pkg::EndBack,  $urandom, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'd0);
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'(Depth - 1));
    send_item(dq_pkg::OP_READ, dq_pkg::EndFront, 32'sd0, 16'(Depth));
    send_item(dq_pkg::OP_NOP,  dq_pkg::EndBack,  $urandom, 16'($urandom));
    while (fill_copy > 0) begin
      send_item(dq_pkg::OP_POP, 1'($urandom), $urandom, 16'($urandom));
      if ($urandom_range(0, 3) == 0 && fill_copy > 0)
        send_item(dq_pkg::OP_READ, dq_pkg::EndFront, $urandom,
                  16'($urandom_range(0, fill_copy - 1)));
    end
    send_item(dq_pkg::OP_POP, dq_pkg::EndBack, 32'sd0, 16'd0);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < 95; i++) send_random((phase % 2 == 0) ? 55 : 20);
    end
  endtask

  task automatic test_settle_pause();
    for (int round = 0; round < 3; round++) begin
      for (int i = 0; i < 10; i++) send_random(40);
      wait_settled();
    end
  endtask

  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, status_o}, '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o != want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (read_data_o != want.data) report_mismatch("read_data", read_data_o, want.data);
        if (entry_count_o != want.count)
          report_mismatch("entry_count", 32'(entry_count_o), 32'(want.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    head_copy      = 0;
    fill_copy      = 0;
    mismatch_count = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_drain();
    test_settle_pause();
    test_random_mix();
    wait_settled();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
